// File: src/csvfs_pkg.sv
// shared types and constants for the csv field splitter
`timescale 1ns / 1ps
package csvfs_pkg;

	localparam int OFFSET_BITS_DEF = 20;
	localparam int ROW_BITS_DEF = 16;
	localparam int COL_BITS_DEF = 8;

	// register widths are fixed by the register map
	localparam int MODE_W = 2;
	localparam int FROW_W = 16;
	localparam int FCOL_W = 8;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register indexes
	localparam logic [1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [1:0] REG_FILTER_ROW = 2'd1;
	localparam logic [1:0] REG_FILTER_COL = 2'd2;

	// filter modes
	localparam logic [MODE_W-1:0] FILT_ALL = 2'd0;
	localparam logic [MODE_W-1:0] FILT_ROW = 2'd1;
	localparam logic [MODE_W-1:0] FILT_COL = 2'd2;
	localparam logic [MODE_W-1:0] FILT_BOTH = 2'd3;

	// result kinds
	localparam logic KIND_FIELD = 1'b0;
	localparam logic KIND_END = 1'b1;

	// special bytes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	localparam int QDEPTH = 4;

	// what the back end has to emit for one input byte
	typedef struct packed {
		logic has_field;
		logic has_end;
	} flags_t;

	// queue status seen by the front end
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// File: src/csv_field_splitter.sv
// top level of the csv field splitter: register port, front end, queue, back end
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------------------
//  in       | in_valid / in_ready             | data_byte
//  out      | out_valid / out_ready           | kind, field_start, field_end, row_index,
//           |                                 | col_index, last
//  config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// one byte is taken per cycle while the queue is not full; the offset and
// counter update in the front end is registered. results leave at one per
// cycle while out_ready is high; a byte ending a field and the stream gives
// two results. a four-entry queue parts the front end from the output register:
// bytes keep flowing while the output stalls until the queue fills. arst_n
// clears all counters, the queue and the filter registers; no clearing pass is needed.
`timescale 1ns / 1ps
module csv_field_splitter #(
	parameter int OFFSET_BITS = csvfs_pkg::OFFSET_BITS_DEF,
	parameter int ROW_BITS = csvfs_pkg::ROW_BITS_DEF,
	parameter int COL_BITS = csvfs_pkg::COL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [csvfs_pkg::PADDR_W-1:0]     paddr,
	input  logic [csvfs_pkg::PDATA_W-1:0]     pwdata,
	output logic [csvfs_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              kind,
	output logic [OFFSET_BITS-1:0]            field_start,
	output logic [OFFSET_BITS-1:0]            field_end,
	output logic [ROW_BITS-1:0]               row_index,
	output logic [COL_BITS-1:0]               col_index,
	output logic                              last
);
	localparam int FW = $bits(csvfs_pkg::flags_t);
	localparam int QW = FW + 2 * OFFSET_BITS + ROW_BITS + COL_BITS;

	logic [csvfs_pkg::MODE_W-1:0] filter_mode_q;
	logic [csvfs_pkg::FROW_W-1:0] filter_row_q;
	logic [csvfs_pkg::FCOL_W-1:0] filter_col_q;
	logic cfg_wr;
	logic [1:0] reg_idx;

	csvfs_pkg::qstat_t qstat;
	csvfs_pkg::flags_t f_flags;
	csvfs_pkg::flags_t b_flags;
	logic q_push;
	logic q_pop;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;
	logic [OFFSET_BITS-1:0] f_start;
	logic [OFFSET_BITS-1:0] f_end;
	logic [ROW_BITS-1:0] f_row;
	logic [COL_BITS-1:0] f_col;
	logic [OFFSET_BITS-1:0] b_start;
	logic [OFFSET_BITS-1:0] b_end;
	logic [ROW_BITS-1:0] b_row;
	logic [COL_BITS-1:0] b_col;

	// register port
	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= '0;
			filter_row_q <= '0;
			filter_col_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				csvfs_pkg::REG_FILTER_MODE: filter_mode_q <= pwdata[csvfs_pkg::MODE_W-1:0];
				csvfs_pkg::REG_FILTER_ROW:  filter_row_q <= pwdata[csvfs_pkg::FROW_W-1:0];
				csvfs_pkg::REG_FILTER_COL:  filter_col_q <= pwdata[csvfs_pkg::FCOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			csvfs_pkg::REG_FILTER_MODE: prdata = csvfs_pkg::PDATA_W'(filter_mode_q);
			csvfs_pkg::REG_FILTER_ROW:  prdata = csvfs_pkg::PDATA_W'(filter_row_q);
			csvfs_pkg::REG_FILTER_COL:  prdata = csvfs_pkg::PDATA_W'(filter_col_q);
			default:                    prdata = '0;
		endcase
	end

	csvfs_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.ROW_BITS(ROW_BITS),
		.COL_BITS(COL_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.filter_mode(filter_mode_q),
		.filter_row(filter_row_q),
		.filter_col(filter_col_q),
		.qstat(qstat),
		.push(q_push),
		.flags(f_flags),
		.start_off(f_start),
		.end_off(f_end),
		.row_val(f_row),
		.col_val(f_col)
	);

	assign q_wdata = {f_flags, f_start, f_end, f_row, f_col};

	csvfs_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.rdata(q_rdata),
		.stat(qstat)
	);

	assign {b_flags, b_start, b_end, b_row, b_col} = q_rdata;

	csvfs_back #(
		.OFFSET_BITS(OFFSET_BITS),
		.ROW_BITS(ROW_BITS),
		.COL_BITS(COL_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.flags(b_flags),
		.start_off(b_start),
		.end_off(b_end),
		.row_val(b_row),
		.col_val(b_col),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.field_start(field_start),
		.field_end(field_end),
		.row_index(row_index),
		.col_index(col_index),
		.last(last)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("queue push while full");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !qstat.empty)
		else $error("queue pop while empty");

	// an end marker always closes the results of its byte and carries zeros
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == csvfs_pkg::KIND_END) |->
			(last && field_start == '0 && field_end == '0 &&
			 row_index == '0 && col_index == '0))
		else $error("malformed end marker");

	// a field that is not last is followed by its end marker
	a_field_then_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && kind == csvfs_pkg::KIND_FIELD && !last) |=>
			(out_valid && kind == csvfs_pkg::KIND_END))
		else $error("field without last not followed by end marker");

endmodule

// File: src/csvfs_queue.sv
// small flop-based queue between the front and back ends
`timescale 1ns / 1ps
module csvfs_queue #(
	parameter int WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                pop,
	output logic [WIDTH-1:0]    rdata,
	output csvfs_pkg::qstat_t   stat
);
	localparam int DEPTH = csvfs_pkg::QDEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign stat.full = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// File: src/csvfs_front.sv
// front end: takes bytes, tracks offsets and counters, decides what to emit
`timescale 1ns / 1ps
module csvfs_front #(
	parameter int OFFSET_BITS = csvfs_pkg::OFFSET_BITS_DEF,
	parameter int ROW_BITS = csvfs_pkg::ROW_BITS_DEF,
	parameter int COL_BITS = csvfs_pkg::COL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic [csvfs_pkg::MODE_W-1:0]      filter_mode,
	input  logic [csvfs_pkg::FROW_W-1:0]      filter_row,
	input  logic [csvfs_pkg::FCOL_W-1:0]      filter_col,
	input  csvfs_pkg::qstat_t                 qstat,
	output logic                              push,
	output csvfs_pkg::flags_t                 flags,
	output logic [OFFSET_BITS-1:0]            start_off,
	output logic [OFFSET_BITS-1:0]            end_off,
	output logic [ROW_BITS-1:0]               row_val,
	output logic [COL_BITS-1:0]               col_val
);
	localparam int RW = (ROW_BITS > csvfs_pkg::FROW_W) ? ROW_BITS : csvfs_pkg::FROW_W;
	localparam int CLW = (COL_BITS > csvfs_pkg::FCOL_W) ? COL_BITS : csvfs_pkg::FCOL_W;

	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] begin_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;
	logic after_cr_q;

	logic accept;
	logic lf_skip;
	logic is_nul;
	logic is_comma;
	logic is_brk;
	logic row_ok;
	logic col_ok;
	logic pass;
	logic [OFFSET_BITS-1:0] offset_nx;

	assign in_ready = !qstat.full;
	assign accept = in_valid && in_ready;

	assign lf_skip = after_cr_q && (data_byte == csvfs_pkg::CH_LF);
	assign is_nul = (data_byte == csvfs_pkg::CH_NUL);
	assign is_comma = (data_byte == csvfs_pkg::CH_COMMA);
	assign is_brk = (data_byte == csvfs_pkg::CH_CR) || (data_byte == csvfs_pkg::CH_LF);
	assign offset_nx = (offset_q == '1) ? offset_q : offset_q + 1'b1;

	assign row_ok = (RW'(row_q) == RW'(filter_row));
	assign col_ok = (CLW'(col_q) == CLW'(filter_col));

	always_comb begin
		case (filter_mode)
			csvfs_pkg::FILT_ALL:  pass = 1'b1;
			csvfs_pkg::FILT_ROW:  pass = row_ok;
			csvfs_pkg::FILT_COL:  pass = col_ok;
			csvfs_pkg::FILT_BOTH: pass = row_ok && col_ok;
			default:              pass = 1'b1;
		endcase
	end

	always_comb begin
		flags.has_field = 1'b0;
		flags.has_end = 1'b0;
		if (!lf_skip) begin
			if (is_nul) begin
				flags.has_field = pass && (offset_q != begin_q);
				flags.has_end = 1'b1;
			end else if (is_comma || is_brk) begin
				flags.has_field = pass;
			end
		end
	end

	assign push = accept && (flags.has_field || flags.has_end);
	assign start_off = begin_q;
	assign end_off = offset_q;
	assign row_val = row_q;
	assign col_val = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			begin_q <= '0;
			row_q <= '0;
			col_q <= '0;
			after_cr_q <= 1'b0;
		end else if (accept) begin
			after_cr_q <= 1'b0;
			if (lf_skip) begin
				offset_q <= offset_nx;
				begin_q <= offset_nx;
			end else if (is_nul) begin
				offset_q <= '0;
				begin_q <= '0;
				row_q <= '0;
				col_q <= '0;
			end else if (is_comma) begin
				offset_q <= offset_nx;
				begin_q <= offset_nx;
				col_q <= (col_q == '1) ? col_q : col_q + 1'b1;
			end else if (is_brk) begin
				offset_q <= offset_nx;
				begin_q <= offset_nx;
				row_q <= (row_q == '1) ? row_q : row_q + 1'b1;
				col_q <= '0;
				after_cr_q <= (data_byte == csvfs_pkg::CH_CR);
			end else begin
				offset_q <= offset_nx;
			end
		end
	end

endmodule

// File: src/csvfs_back.sv
// back end: drains queue entries into the output register, one result per cycle while out_ready is high
`timescale 1ns / 1ps
module csvfs_back #(
	parameter int OFFSET_BITS = csvfs_pkg::OFFSET_BITS_DEF,
	parameter int ROW_BITS = csvfs_pkg::ROW_BITS_DEF,
	parameter int COL_BITS = csvfs_pkg::COL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  csvfs_pkg::qstat_t         qstat,
	input  csvfs_pkg::flags_t         flags,
	input  logic [OFFSET_BITS-1:0]    start_off,
	input  logic [OFFSET_BITS-1:0]    end_off,
	input  logic [ROW_BITS-1:0]       row_val,
	input  logic [COL_BITS-1:0]       col_val,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      kind,
	output logic [OFFSET_BITS-1:0]    field_start,
	output logic [OFFSET_BITS-1:0]    field_end,
	output logic [ROW_BITS-1:0]       row_index,
	output logic [COL_BITS-1:0]       col_index,
	output logic                      last
);
	logic field_done_q;
	logic out_valid_q;
	logic kind_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [OFFSET_BITS-1:0] end_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;
	logic last_q;

	logic load;
	logic cur_field;

	// the field result of an entry goes out before its end marker
	assign cur_field = flags.has_field && !field_done_q;
	assign load = !qstat.empty && (!out_valid_q || out_ready);
	assign pop = load && (!cur_field || !flags.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			field_done_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				field_done_q <= cur_field && flags.has_end;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= cur_field ? csvfs_pkg::KIND_FIELD : csvfs_pkg::KIND_END;
			start_q <= cur_field ? start_off : '0;
			end_q <= cur_field ? end_off : '0;
			row_q <= cur_field ? row_val : '0;
			col_q <= cur_field ? col_val : '0;
			last_q <= !cur_field || !flags.has_end;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign field_start = start_q;
	assign field_end = end_q;
	assign row_index = row_q;
	assign col_index = col_q;
	assign last = last_q;

endmodule

// File: dv/csv_field_splitter_tb.sv
// testbench for csv_field_splitter: random byte streams checked against a field predictor
`timescale 1ns / 1ps
module csv_field_splitter_tb;

	localparam int OW = csvfs_pkg::OFFSET_BITS_DEF;
	localparam int RW = csvfs_pkg::ROW_BITS_DEF;
	localparam int CW = csvfs_pkg::COL_BITS_DEF;
	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic kind;
		logic [OW-1:0] start;
		logic [OW-1:0] stop;
		logic [RW-1:0] row;
		logic [CW-1:0] col;
		logic last;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [csvfs_pkg::PADDR_W-1:0] paddr = '0;
	logic [csvfs_pkg::PDATA_W-1:0] pwdata = '0;
	logic [csvfs_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [OW-1:0] field_start;
	logic [OW-1:0] field_end;
	logic [RW-1:0] row_index;
	logic [CW-1:0] col_index;
	logic last;

	csv_field_splitter dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .field_start(field_start), .field_end(field_end),
		.row_index(row_index), .col_index(col_index), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state and filter settings
	logic [csvfs_pkg::MODE_W-1:0] cfg_mode = csvfs_pkg::FILT_ALL;
	logic [csvfs_pkg::FROW_W-1:0] cfg_row = '0;
	logic [csvfs_pkg::FCOL_W-1:0] cfg_col = '0;
	logic [OW-1:0] tok_ofs = '0;
	logic [OW-1:0] tok_begin = '0;
	logic [RW-1:0] tok_row = '0;
	logic [CW-1:0] tok_col = '0;
	logic tok_after_cr = 1'b0;

	logic [7:0] byte_q[$];
	token_t expected_tokens[$];
	int failures = 0;
	int queued_bytes = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int ready_mode = 0;
	int mode_left = 0;

	function automatic bit field_passes();
		bit row_ok;
		bit col_ok;
		row_ok = (tok_row == cfg_row);
		col_ok = (tok_col == cfg_col);
		case (cfg_mode)
			csvfs_pkg::FILT_ROW: return row_ok;
			csvfs_pkg::FILT_COL: return col_ok;
			csvfs_pkg::FILT_BOTH: return row_ok && col_ok;
			default: return 1'b1;
		endcase
	endfunction

	// works out the results one accepted byte causes and queues them
	task automatic tokenize_byte(input logic [7:0] b);
		token_t found[$];
		token_t t;
		logic [OW-1:0] nxt;
		if (tok_after_cr && b == csvfs_pkg::CH_LF) begin
			tok_after_cr = 1'b0;
			if (tok_ofs != '1)
				tok_ofs = tok_ofs + 1'b1;
			tok_begin = tok_ofs;
			return;
		end
		tok_after_cr = 1'b0;
		nxt = (tok_ofs == '1) ? tok_ofs : tok_ofs + 1'b1;
		t = '{csvfs_pkg::KIND_FIELD, tok_begin, tok_ofs, tok_row, tok_col, 1'b0};
		if (b == csvfs_pkg::CH_NUL) begin
			if (tok_ofs != tok_begin && field_passes())
				found.push_back(t);
			found.push_back('{csvfs_pkg::KIND_END, '0, '0, '0, '0, 1'b0});
			tok_ofs = '0;
			tok_begin = '0;
			tok_row = '0;
			tok_col = '0;
		end else if (b == csvfs_pkg::CH_COMMA) begin
			if (field_passes())
				found.push_back(t);
			if (tok_col != '1)
				tok_col = tok_col + 1'b1;
			tok_ofs = nxt;
			tok_begin = nxt;
		end else if (b == csvfs_pkg::CH_CR || b == csvfs_pkg::CH_LF) begin
			if (field_passes())
				found.push_back(t);
			if (tok_row != '1)
				tok_row = tok_row + 1'b1;
			tok_col = '0;
			tok_after_cr = (b == csvfs_pkg::CH_CR);
			tok_ofs = nxt;
			tok_begin = nxt;
		end else begin
			tok_ofs = nxt;
		end
		if (found.size() != 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[i])
			expected_tokens.push_back(found[i]);
	endtask

	// sender: bursts of requests with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				tokenize_byte(data_byte);
				void'(byte_q.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(24, 1);
					gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				in_valid <= 1'b1;
				data_byte <= byte_q[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: changing stall patterns plus occasional long hold-offs
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(3, 0);
				mode_left = $urandom_range(80, 16);
			end else begin
				mode_left--;
			end
			if (hold_ack != hold_req) begin
				hold_ack = hold_req;
				hold_left = 90;
			end else if (hold_left == 0 && $urandom_range(499, 0) == 0) begin
				hold_left = $urandom_range(60, 30);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (ready_mode)
					0, 1: out_ready <= 1'b1;
					2: out_ready <= 1'($urandom_range(1, 0));
					default: out_ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			failures++;
			if (failures <= 30)
				$display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		token_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				failures++;
				if (failures <= 30)
					$display("%0t unexpected result: expected none, got kind=%0d start=%0d end=%0d",
						$time, kind, field_start, field_end);
			end else begin
				want = expected_tokens.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("field_start", 32'(want.start), 32'(field_start));
				check_field("field_end", 32'(want.stop), 32'(field_end));
				check_field("row_index", 32'(want.row), 32'(row_index));
				check_field("col_index", 32'(want.col), 32'(col_index));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			csvfs_pkg::REG_FILTER_MODE: cfg_mode = value[csvfs_pkg::MODE_W-1:0];
			csvfs_pkg::REG_FILTER_ROW: cfg_row = value[csvfs_pkg::FROW_W-1:0];
			csvfs_pkg::REG_FILTER_COL: cfg_col = value[csvfs_pkg::FCOL_W-1:0];
			default: ;
		endcase
	endtask

	// block idle: no request left, no result outstanding, pipeline flushed
	task automatic drain();
		while (byte_q.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void put(input logic [7:0] b);
		byte_q.push_back(b);
		queued_bytes++;
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		if ($urandom_range(5, 0) == 0) begin
			c = 8'($urandom_range(255, 1));
		end else begin
			c = 8'($urandom_range(126, 32));
			if (c == csvfs_pkg::CH_COMMA)
				c = 8'h3b;
		end
		return c;
	endfunction

	// rows of short fields with mixed line breaks, some noise, ends with a zero byte
	task automatic add_records(input int nbytes, input int max_cols);
		int first;
		int ncols;
		first = queued_bytes;
		while (queued_bytes - first < nbytes) begin
			ncols = $urandom_range(max_cols, 1);
			for (int c = 0; c < ncols; c++) begin
				repeat ($urandom_range(4, 0)) put(text_char());
				if ($urandom_range(7, 0) == 0)
					put(8'($urandom_range(255, 0)));
				if (c != ncols - 1)
					put(csvfs_pkg::CH_COMMA);
			end
			case ($urandom_range(3, 0))
				0: begin
					put(csvfs_pkg::CH_CR);
					put(csvfs_pkg::CH_LF);
				end
				1: put(csvfs_pkg::CH_LF);
				2: put(csvfs_pkg::CH_CR);
				default: begin
					put(csvfs_pkg::CH_LF);
					put(csvfs_pkg::CH_LF);
				end
			endcase
			if ($urandom_range(5, 0) == 0)
				put(csvfs_pkg::CH_NUL);
		end
		put(csvfs_pkg::CH_NUL);
	endtask

	initial begin
		static logic [7:0] dir_bytes [22] = '{8'h61, csvfs_pkg::CH_COMMA, 8'hff,
			csvfs_pkg::CH_CR, csvfs_pkg::CH_LF, csvfs_pkg::CH_COMMA, 8'h22,
			csvfs_pkg::CH_LF, csvfs_pkg::CH_LF, csvfs_pkg::CH_CR, csvfs_pkg::CH_CR,
			8'h78, csvfs_pkg::CH_NUL, csvfs_pkg::CH_COMMA, csvfs_pkg::CH_NUL,
			8'h80, 8'h7f, csvfs_pkg::CH_NUL, csvfs_pkg::CH_CR, csvfs_pkg::CH_NUL,
			csvfs_pkg::CH_LF, csvfs_pkg::CH_NUL};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty fields, cr-lf pairs, lf-lf, lone cr, end with and without pending
		foreach (dir_bytes[i])
			put(dir_bytes[i]);
		drain();

		write_reg(csvfs_pkg::REG_FILTER_MODE, 32'(csvfs_pkg::FILT_ALL));
		hold_req++;
		add_records(110, 6);
		drain();

		write_reg(csvfs_pkg::REG_FILTER_MODE, 32'(csvfs_pkg::FILT_ROW));
		write_reg(csvfs_pkg::REG_FILTER_ROW, 32'd1);
		add_records(60, 4);
		drain();

		write_reg(csvfs_pkg::REG_FILTER_MODE, 32'(csvfs_pkg::FILT_COL));
		write_reg(csvfs_pkg::REG_FILTER_COL, 32'd2);
		add_records(60, 5);
		drain();

		write_reg(csvfs_pkg::REG_FILTER_MODE, 32'(csvfs_pkg::FILT_BOTH));
		write_reg(csvfs_pkg::REG_FILTER_ROW, 32'd0);
		write_reg(csvfs_pkg::REG_FILTER_COL, 32'd1);
		add_records(60, 4);
		drain();

		// one very wide row so the column count saturates
		write_reg(csvfs_pkg::REG_FILTER_MODE, 32'(csvfs_pkg::FILT_COL));
		write_reg(csvfs_pkg::REG_FILTER_COL, 32'hffff_ffff);
		repeat (258) begin
			if ($urandom_range(5, 0) == 0)
				put(text_char());
			put(csvfs_pkg::CH_COMMA);
		end
		put(csvfs_pkg::CH_LF);
		put(csvfs_pkg::CH_NUL);
		drain();

		write_reg(csvfs_pkg::REG_FILTER_MODE, 32'(csvfs_pkg::FILT_ALL));
		write_reg(csvfs_pkg::REG_FILTER_ROW, 32'd0);
		write_reg(csvfs_pkg::REG_FILTER_COL, 32'd0);
		add_records(50, 3);
		drain();

		@(negedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
src/csvfs_pkg.sv
src/csvfs_queue.sv
src/csvfs_front.sv
src/csvfs_back.sv
src/csv_field_splitter.sv
dv/csv_field_splitter_tb.sv
